>>> rtl/bbsd_pkg.sv
// Package for the BGGR superpixel debayer unit: frame limits, register
// codes, field widths and the block record passed down the pipeline.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none
package bbsd_pkg;

    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 1024;

    // One line-store entry per two columns.
    localparam int PAIR_DEPTH = MAX_WIDTH / 2;
    localparam int SLOT_W     = $clog2(PAIR_DEPTH);

    localparam int PIX_W   = 8;
    localparam int HALF_W  = 10;
    localparam int COORD_W = 10;
    // Full frame sizes reach 1024, so they and the counters plus one need 11 bits.
    localparam int SIZE_W  = HALF_W + 1;

    localparam logic [HALF_W-1:0] HALF_TOP_W  = HALF_W'(MAX_WIDTH / 2);
    localparam logic [HALF_W-1:0] HALF_TOP_H  = HALF_W'(MAX_HEIGHT / 2);
    localparam logic [HALF_W-1:0] HALF_RESET  = HALF_W'(400);
    localparam logic [HALF_W-1:0] HALF_MIN    = HALF_W'(1);

    // Register indexes as decoded from paddr[2].
    localparam logic REG_HALF_WIDTH  = 1'b0;
    localparam logic REG_HALF_HEIGHT = 1'b1;

    localparam int IN_TDATA_W  = 8;
    localparam int OUT_FIELD_W = 3 * PIX_W + 2 * COORD_W;
    localparam int OUT_TDATA_W = ((OUT_FIELD_W + 7) / 8) * 8;

    typedef struct packed {
        logic [PIX_W-1:0]   red;
        logic [PIX_W-1:0]   lower_green;
        logic [COORD_W-1:0] block_column;
        logic [COORD_W-1:0] block_row;
        logic               frame_end;
    } t_block;

    // A half size of zero acts as one, anything above the top acts as the top.
    function automatic logic [HALF_W-1:0] clamp_half(input logic [HALF_W-1:0] v,
                                                     input logic [HALF_W-1:0] top);
        logic [HALF_W-1:0] r;
        r = v;
        if (v < HALF_MIN) begin
            r = HALF_MIN;
        end else if (v > top) begin
            r = top;
        end
        return r;
    endfunction

endpackage
`default_nettype wire

>>> rtl/bbsd_ram.sv
// Generic simple dual-port RAM: one write port, one read port with a
// registered read that holds its data while no read is issued. Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none
module bbsd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 512
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule
`default_nettype wire

>>> rtl/bayer_bggr_superpixel_debayer_unit.sv
// Top level of the BGGR superpixel debayer: position counters, line store
// (two bbsd_ram instances), block stage and output register.
// Depends on bbsd_pkg and bbsd_ram.
//
//  channel   dir  handshake              payload
//  ------------------------------------------------------------------------
//  s stream  in   i_s_tvalid/o_s_tready  tdata raw_pixel; tuser start_of_frame
//  m stream  out  o_m_tvalid/i_m_tready  tdata red..block_row; tlast frame_end
//  config    in   psel/penable/pwrite    paddr, pwdata, prdata; pready tied high
//
// One pixel item is accepted every cycle while input ready is high. The line
// store is read in the cycle an odd-row odd-column item is accepted; its block
// goes through the block stage and the output register to the m side. These
// decouple the two sides: input ready drops only when both are full and
// i_m_tready is low. Synchronous reset clears counters, sizes (400/400) and
// valid flags; the line store and held green are not cleared.
`timescale 1ns / 1ps
`default_nettype none
module bayer_bggr_superpixel_debayer_unit
    import bbsd_pkg::*;
(
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    // Input item stream.
    input  wire logic                   i_s_tvalid,
    output logic                        o_s_tready,
    input  wire logic [IN_TDATA_W-1:0]  i_s_tdata,   // [7:0] raw_pixel
    input  wire logic [0:0]             i_s_tuser,   // [0] start_of_frame
    // Result item stream.
    output logic                        o_m_tvalid,
    input  wire logic                   i_m_tready,
    output logic [OUT_TDATA_W-1:0]      o_m_tdata,   // [7:0] red, [15:8] green,
                                                     // [23:16] blue, [33:24] block_column,
                                                     // [43:34] block_row, [47:44] zero
    output logic                        o_m_tlast,   // frame_end
    // Configuration port.
    input  wire logic                   psel,
    input  wire logic                   penable,
    input  wire logic                   pwrite,
    input  wire logic [2:0]             paddr,
    input  wire logic [31:0]            pwdata,
    output logic      [31:0]            prdata,
    output logic                        pready
);

    // ---------------------------------------------------------------- config
    logic [HALF_W-1:0] r_half_width;
    logic [HALF_W-1:0] r_half_height;
    logic              cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_half_width  <= HALF_RESET;
            r_half_height <= HALF_RESET;
        end else if (cfg_wr) begin
            case (paddr[2])
                REG_HALF_WIDTH:  r_half_width  <= pwdata[HALF_W-1:0];
                REG_HALF_HEIGHT: r_half_height <= pwdata[HALF_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            REG_HALF_WIDTH:  prdata = 32'(r_half_width);
            REG_HALF_HEIGHT: prdata = 32'(r_half_height);
            default:         prdata = '0;
        endcase
    end

    // ------------------------------------------------------------- handshake
    logic   r_s1_vld;
    t_block r_s1;
    logic   r_out_vld;
    logic   s1_adv;
    logic   accept;

    assign s1_adv     = !r_out_vld || i_m_tready;
    assign o_s_tready = !r_s1_vld || s1_adv;
    assign accept     = i_s_tvalid && o_s_tready;

    // -------------------------------------------------------------- position
    logic [COORD_W-1:0] r_col;
    logic [COORD_W-1:0] r_row;
    logic [PIX_W-1:0]   r_lower_green;

    logic [SIZE_W-1:0]  frame_w;
    logic [SIZE_W-1:0]  frame_h;
    logic [COORD_W-1:0] col0, row0, col1, row1;
    logic [SIZE_W-1:0]  row1_inc, col2_inc, row2_inc;
    logic [COORD_W-1:0] n_col, n_row;
    logic [PIX_W-1:0]   px;
    logic [SLOT_W-1:0]  slot;
    logic               even_row, even_col, is_result;

    assign frame_w = {clamp_half(r_half_width, HALF_TOP_W), 1'b0};
    assign frame_h = {clamp_half(r_half_height, HALF_TOP_H), 1'b0};
    assign px      = i_s_tdata[PIX_W-1:0];

    always_comb begin
        // Start of frame, then wrap the stored position against the current size.
        col0     = i_s_tuser[0] ? '0 : r_col;
        row0     = i_s_tuser[0] ? '0 : r_row;
        row1_inc = SIZE_W'(row0);
        col1     = col0;
        if (SIZE_W'(col0) >= frame_w) begin
            col1     = '0;
            row1_inc = SIZE_W'(row0) + SIZE_W'(1);
        end
        row1 = (row1_inc >= frame_h) ? '0 : row1_inc[COORD_W-1:0];

        // Advance past this pixel and wrap again.
        col2_inc = SIZE_W'(col1) + SIZE_W'(1);
        row2_inc = SIZE_W'(row1);
        n_col    = col2_inc[COORD_W-1:0];
        if (col2_inc >= frame_w) begin
            n_col    = '0;
            row2_inc = SIZE_W'(row1) + SIZE_W'(1);
        end
        n_row = (row2_inc >= frame_h) ? '0 : row2_inc[COORD_W-1:0];
    end

    assign slot      = col1[COORD_W-1:1];
    assign even_row  = !row1[0];
    assign even_col  = !col1[0];
    assign is_result = !even_row && !even_col;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (accept) begin
            r_col <= n_col;
            r_row <= n_row;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && !even_row && even_col) begin
            r_lower_green <= px;
        end
    end

    // ------------------------------------------------------------ line store
    logic [PIX_W-1:0] blue_rd;
    logic [PIX_W-1:0] upper_rd;
    logic             rd_en;

    assign rd_en = accept && is_result;

    bbsd_ram #(.WIDTH(PIX_W), .DEPTH(PAIR_DEPTH)) u_blue_ram (
        .i_clk   (i_clk),
        .i_we    (accept && even_row && even_col),
        .i_waddr (slot),
        .i_wdata (px),
        .i_re    (rd_en),
        .i_raddr (slot),
        .o_rdata (blue_rd)
    );

    bbsd_ram #(.WIDTH(PIX_W), .DEPTH(PAIR_DEPTH)) u_green_ram (
        .i_clk   (i_clk),
        .i_we    (accept && even_row && !even_col),
        .i_waddr (slot),
        .i_wdata (px),
        .i_re    (rd_en),
        .i_raddr (slot),
        .o_rdata (upper_rd)
    );

    // ----------------------------------------------------------- block stage
    t_block n_s1;

    always_comb begin
        n_s1.red          = px;
        n_s1.lower_green  = r_lower_green;
        n_s1.block_column = col1 - COORD_W'(1);
        n_s1.block_row    = row1 - COORD_W'(1);
        n_s1.frame_end    = (SIZE_W'(col1) + SIZE_W'(1) == frame_w) &&
                            (SIZE_W'(row1) + SIZE_W'(1) == frame_h);
    end

    // The RAM read data only changes on a new read, which happens only when
    // this stage is free, so it stays aligned with r_s1 while stalled.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else if (o_s_tready) begin
            r_s1_vld <= rd_en;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_s1 <= n_s1;
        end
    end

    // --------------------------------------------------------- output stage
    logic [PIX_W:0]     green_sum;
    logic [PIX_W-1:0]   r_out_red, r_out_green, r_out_blue;
    logic [COORD_W-1:0] r_out_col, r_out_row;
    logic               r_out_last;

    assign green_sum = {1'b0, upper_rd} + {1'b0, r_s1.lower_green};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (s1_adv) begin
            r_out_vld <= r_s1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv && r_s1_vld) begin
            r_out_red   <= r_s1.red;
            r_out_green <= green_sum[PIX_W:1];
            r_out_blue  <= blue_rd;
            r_out_col   <= r_s1.block_column;
            r_out_row   <= r_s1.block_row;
            r_out_last  <= r_s1.frame_end;
        end
    end

    assign o_m_tvalid = r_out_vld;
    assign o_m_tdata  = OUT_TDATA_W'({r_out_row, r_out_col, r_out_blue,
                                      r_out_green, r_out_red});
    assign o_m_tlast  = r_out_last;

`ifndef SYNTHESIS
    // Input back-pressure only comes from a full block stage behind a full, stalled output.
    a_stall_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_s_tready |-> (r_s1_vld && r_out_vld && !i_m_tready))
        else $error("input stalled without a full pipeline");

    // A result item always enters the block stage.
    a_result_enters: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && is_result) |=> r_s1_vld)
        else $error("result item lost at block stage");

    // Block coordinates are top-left corners and therefore even.
    a_even_coords: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (!r_out_col[0] && !r_out_row[0]))
        else $error("odd block coordinate on output");

    // Stored position never exceeds the largest frame.
    a_pos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (SIZE_W'(r_col) < SIZE_W'(MAX_WIDTH)) && (SIZE_W'(r_row) < SIZE_W'(MAX_HEIGHT)))
        else $error("position counter out of range");
`endif

endmodule
`default_nettype wire

>>> test/bayer_bggr_superpixel_debayer_unit_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for the BGGR superpixel debayer unit. Streams raw
// pixels and APB size writes, predicts each block colour and checks every item.
// Depends on bbsd_pkg and the RTL of bayer_bggr_superpixel_debayer_unit.
module bayer_bggr_superpixel_debayer_unit_tb;
    import bbsd_pkg::*;

    localparam int CLK_PERIOD    = 12;
    localparam int RESET_CYCLES  = 11;
    localparam int STALL_LIMIT   = 3000;
    localparam int DRAIN_CYCLES  = 6;
    localparam int HOLD_CYCLES   = 300;
    localparam int HOLD_AFTER    = 40;
    localparam int RANDOM_PIXELS = 1180;
    localparam int NUM_DIRECTED  = 19;

    localparam logic [2:0] ADDR_HALF_WIDTH  = {REG_HALF_WIDTH, 2'b00};
    localparam logic [2:0] ADDR_HALF_HEIGHT = {REG_HALF_HEIGHT, 2'b00};

    typedef struct packed {
        logic [PIX_W-1:0]   red;
        logic [PIX_W-1:0]   green;
        logic [PIX_W-1:0]   blue;
        logic [COORD_W-1:0] bcol;
        logic [COORD_W-1:0] brow;
        logic               last;
    } t_exp_block;

    typedef struct packed {
        logic [PIX_W-1:0] px;
        logic             sof;
        logic             typed;
        t_exp_block       blk;
    } t_directed_row;

    localparam t_exp_block NO_BLOCK = '0;

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   i_s_tvalid;
    logic                   o_s_tready;
    logic [IN_TDATA_W-1:0]  i_s_tdata;
    logic [0:0]             i_s_tuser;
    logic                   o_m_tvalid;
    logic                   i_m_tready;
    logic [OUT_TDATA_W-1:0] o_m_tdata;
    logic                   o_m_tlast;
    logic                   psel;
    logic                   penable;
    logic                   pwrite;
    logic [2:0]             paddr;
    logic [31:0]            pwdata;
    logic [31:0]            prdata;
    logic                   pready;

    // Predictor state: register copies, frame position and line store.
    logic [HALF_W-1:0] cfg_half_width;
    logic [HALF_W-1:0] cfg_half_height;
    int                pos_col;
    int                pos_row;
    logic [PIX_W-1:0]  blue_line [PAIR_DEPTH];
    logic [PIX_W-1:0]  upper_green_line [PAIR_DEPTH];
    bit                blue_written [PAIR_DEPTH];
    bit                green_written [PAIR_DEPTH];
    logic [PIX_W-1:0]  held_green;

    t_exp_block    expected_blocks [$];
    t_directed_row directed_rows [NUM_DIRECTED];
    int            pixels_sent  = 0;
    int            results_seen = 0;
    int            fail_count   = 0;

    bayer_bggr_superpixel_debayer_unit dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tlast  (o_m_tlast),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    initial begin
        i_clk = 1'b0;
        forever #(CLK_PERIOD / 2) i_clk = ~i_clk;
    end

    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            fail_count++;
        end
    endfunction

    // Mostly back-to-back, sometimes a short gap, rarely a long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 65) return 0;
        if (r < 92) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 10);
        return $urandom_range(15, 40);
    endfunction

    function automatic logic [HALF_W-1:0] pick_half();
        int r;
        r = $urandom_range(0, 99);
        if (r < 5) return '0;
        if (r < 10) return HALF_W'($urandom_range(600, 1023));
        if (r < 25) return HALF_W'($urandom_range(5, 32));
        return HALF_W'($urandom_range(1, 4));
    endfunction

    function automatic int full_size(input logic [HALF_W-1:0] half, input int max_full);
        int v;
        v = half;
        if (v < 1) v = 1;
        if (v > max_full / 2) v = max_full / 2;
        return 2 * v;
    endfunction

    function automatic void wrap_position(input int w, input int h);
        if (pos_col >= w) begin
            pos_col = 0;
            pos_row++;
        end
        if (pos_row >= h) pos_row = 0;
    endfunction

    // True when the next pixel, sent without a start mark, would finish a block
    // over a line-store entry that has not been filled yet.
    function automatic bit next_reads_empty();
        int w;
        int h;
        int col;
        int row;
        w   = full_size(cfg_half_width, MAX_WIDTH);
        h   = full_size(cfg_half_height, MAX_HEIGHT);
        col = pos_col;
        row = pos_row;
        if (col >= w) begin
            col = 0;
            row++;
        end
        if (row >= h) row = 0;
        return (row % 2 == 1) && (col % 2 == 1) &&
               !(blue_written[col / 2] && green_written[col / 2]);
    endfunction

    // Advances the frame position by one pixel and returns the block colour
    // when the pixel sits at an odd row and odd column.
    function automatic void debayer_pixel(input logic [PIX_W-1:0] px, input logic sof,
                                          output bit got, output t_exp_block blk);
        int w;
        int h;
        int slot;
        logic [PIX_W:0] green_sum;
        w = full_size(cfg_half_width, MAX_WIDTH);
        h = full_size(cfg_half_height, MAX_HEIGHT);
        got = 1'b0;
        blk = NO_BLOCK;
        if (sof) begin
            pos_col = 0;
            pos_row = 0;
        end
        wrap_position(w, h);
        slot = pos_col / 2;
        if (pos_row % 2 == 0) begin
            if (pos_col % 2 == 0) begin
                blue_line[slot]    = px;
                blue_written[slot] = 1'b1;
            end else begin
                upper_green_line[slot] = px;
                green_written[slot]    = 1'b1;
            end
        end else if (pos_col % 2 == 0) begin
            held_green = px;
        end else begin
            green_sum = {1'b0, upper_green_line[slot]} + {1'b0, held_green};
            blk.red   = px;
            blk.green = green_sum[PIX_W:1];
            blk.blue  = blue_line[slot];
            blk.bcol  = COORD_W'(pos_col - 1);
            blk.brow  = COORD_W'(pos_row - 1);
            blk.last  = (pos_col + 1 == w) && (pos_row + 1 == h);
            got = 1'b1;
        end
        pos_col++;
        wrap_position(w, h);
    endfunction

    task automatic send_pixel(input logic [PIX_W-1:0] px, input logic sof, input int gap,
                              output bit got, output t_exp_block blk);
        if (gap > 0) begin
            @(negedge i_clk);
            i_s_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= px;
        i_s_tuser  <= sof;
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        pixels_sent++;
        debayer_pixel(px, sof, got, blk);
    endtask

    task automatic apb_access(input logic write, input logic [2:0] addr,
                              input logic [31:0] wdata, output logic [31:0] rdata);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= write;
        paddr   <= addr;
        pwdata  <= wdata;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        rdata = prdata;
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Upper data bits carry junk; only the low ten bits belong to a register.
    task automatic set_frame(input logic [HALF_W-1:0] half_w, input logic [HALF_W-1:0] half_h);
        logic [31:0] junk;
        logic [31:0] rdata;
        junk = $urandom();
        apb_access(1'b1, ADDR_HALF_WIDTH, {junk[31:HALF_W], half_w}, rdata);
        cfg_half_width = half_w;
        junk = $urandom();
        apb_access(1'b1, ADDR_HALF_HEIGHT, {junk[31:HALF_W], half_h}, rdata);
        cfg_half_height = half_h;
        apb_access(1'b0, ADDR_HALF_WIDTH, '0, rdata);
        check_field("half_width readback", 32'(half_w), rdata);
        apb_access(1'b0, ADDR_HALF_HEIGHT, '0, rdata);
        check_field("half_height readback", 32'(half_h), rdata);
    endtask

    // Well-formed frames with random content; a noisy phase also drops
    // start-of-frame marks into the middle of frames. A pixel that would
    // finish a block over a line-store entry never filled restarts the frame.
    task automatic stream_phase(input int count, input bit noisy);
        bit         burst;
        bit         got;
        t_exp_block blk;
        logic       sof;
        burst = ($urandom_range(0, 3) == 0);
        repeat (count) begin
            if (pos_col == 0 && pos_row == 0) sof = ($urandom_range(0, 4) != 0);
            else sof = noisy && ($urandom_range(0, 59) == 0);
            if (!sof && next_reads_empty()) sof = 1'b1;
            send_pixel(PIX_W'($urandom_range(0, 255)), sof, burst ? 0 : pick_gap(), got, blk);
            if (got) expected_blocks.push_back(blk);
        end
    endtask

    task automatic drain_results();
        @(negedge i_clk);
        i_s_tvalid <= 1'b0;
        while (expected_blocks.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    always @(posedge i_clk) begin : check_results
        t_exp_block want;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            results_seen++;
            if (expected_blocks.size() == 0) begin
                $display("%0t: unexpected item, expected none, actual tdata %h tlast %b",
                         $time, o_m_tdata, o_m_tlast);
                fail_count++;
            end else begin
                want = expected_blocks.pop_front();
                check_field("red", want.red, o_m_tdata[7:0]);
                check_field("green", want.green, o_m_tdata[15:8]);
                check_field("blue", want.blue, o_m_tdata[23:16]);
                check_field("block_column", want.bcol, o_m_tdata[33:24]);
                check_field("block_row", want.brow, o_m_tdata[43:34]);
                check_field("frame_end", want.last, o_m_tlast);
            end
        end
    end

    initial begin : result_sink
        int stall_left;
        int mode_left;
        bit steady;
        bit held_once;
        stall_left = 0;
        mode_left  = 0;
        steady     = 1'b0;
        held_once  = 1'b0;
        i_m_tready = 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            @(negedge i_clk);
            if (!held_once && results_seen >= HOLD_AFTER) begin
                // One long hold-off while pixels keep coming, so the input stalls.
                held_once  = 1'b1;
                stall_left = HOLD_CYCLES;
            end else if (stall_left == 0) begin
                if (mode_left == 0) begin
                    steady    = ($urandom_range(0, 3) == 0);
                    mode_left = $urandom_range(50, 200);
                end
                mode_left--;
                if (!steady) stall_left = pick_gap();
            end
            if (stall_left > 0) begin
                i_m_tready <= 1'b0;
                stall_left--;
            end else begin
                i_m_tready <= 1'b1;
            end
        end
    end

    initial begin : watchdog
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready)) idle_cycles = 0;
            else idle_cycles++;
        end
        $display("%0t: no item moved for %0d cycles", $time, STALL_LIMIT);
        $display("== FAIL ==");
        $finish;
    end

    initial begin : stimulus
        logic [31:0] rdata;
        bit          got;
        t_exp_block  blk;
        int          random_pixels;
        int          phase_len;
        int          phase_count;

        i_rst_n    = 1'b0;
        i_s_tvalid = 1'b0;
        i_s_tdata  = '0;
        i_s_tuser  = '0;
        psel       = 1'b0;
        penable    = 1'b0;
        pwrite     = 1'b0;
        paddr      = '0;
        pwdata     = '0;
        cfg_half_width  = HALF_RESET;
        cfg_half_height = HALF_RESET;
        pos_col = 0;
        pos_row = 0;

        // 2x2 frames. Typed rows: all-ones block, all-zeros block after a frame
        // wrap without a start mark, green rounding down, and a start mark that
        // lands where the red pixel was due.
        directed_rows = '{
            '{8'hFF, 1'b1, 1'b0, NO_BLOCK},
            '{8'hFF, 1'b0, 1'b0, NO_BLOCK},
            '{8'hFF, 1'b0, 1'b0, NO_BLOCK},
            '{8'hFF, 1'b0, 1'b1, '{8'hFF, 8'hFF, 8'hFF, 10'd0, 10'd0, 1'b1}},
            '{8'h00, 1'b0, 1'b0, NO_BLOCK},
            '{8'h00, 1'b0, 1'b0, NO_BLOCK},
            '{8'h00, 1'b0, 1'b0, NO_BLOCK},
            '{8'h00, 1'b0, 1'b1, '{8'h00, 8'h00, 8'h00, 10'd0, 10'd0, 1'b1}},
            '{8'h12, 1'b1, 1'b0, NO_BLOCK},
            '{8'hFF, 1'b0, 1'b0, NO_BLOCK},
            '{8'h00, 1'b0, 1'b0, NO_BLOCK},
            '{8'h34, 1'b0, 1'b1, '{8'h34, 8'h7F, 8'h12, 10'd0, 10'd0, 1'b1}},
            '{8'hAA, 1'b0, 1'b0, NO_BLOCK},
            '{8'h01, 1'b0, 1'b0, NO_BLOCK},
            '{8'h02, 1'b0, 1'b0, NO_BLOCK},
            '{8'h55, 1'b1, 1'b0, NO_BLOCK},
            '{8'h03, 1'b0, 1'b0, NO_BLOCK},
            '{8'h04, 1'b0, 1'b0, NO_BLOCK},
            '{8'hC3, 1'b0, 1'b1, '{8'hC3, 8'h03, 8'h55, 10'd0, 10'd0, 1'b1}}
        };

        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        apb_access(1'b0, ADDR_HALF_WIDTH, '0, rdata);
        check_field("half_width after reset", 32'(HALF_RESET), rdata);
        apb_access(1'b0, ADDR_HALF_HEIGHT, '0, rdata);
        check_field("half_height after reset", 32'(HALF_RESET), rdata);

        set_frame(10'd1, 10'd1);
        foreach (directed_rows[i]) begin
            send_pixel(directed_rows[i].px, directed_rows[i].sof, pick_gap(), got, blk);
            if (directed_rows[i].typed) expected_blocks.push_back(directed_rows[i].blk);
            else if (got) expected_blocks.push_back(blk);
        end
        drain_results();

        // Phases end at random points, so each new size lands mid-frame.
        random_pixels = 0;
        phase_count   = 1;
        while (random_pixels < RANDOM_PIXELS) begin
            set_frame(pick_half(), pick_half());
            phase_len = $urandom_range(40, 160);
            if (phase_len > RANDOM_PIXELS - random_pixels) begin
                phase_len = RANDOM_PIXELS - random_pixels;
            end
            stream_phase(phase_len, 1'b1);
            random_pixels += phase_len;
            phase_count++;
            drain_results();
        end

        $display("Sent %0d pixels over %0d size settings and checked %0d blocks.",
                 pixels_sent, phase_count, results_seen);
        $display("Frame sizes ran from 2x2 up to the clamped maximum, with size changes "
                 , "mid-frame, stray start marks and one long output hold-off.");
        if (fail_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

>>> bayer_bggr_superpixel_debayer_unit.f
rtl/bbsd_pkg.sv
rtl/bbsd_ram.sv
rtl/bayer_bggr_superpixel_debayer_unit.sv
test/bayer_bggr_superpixel_debayer_unit_tb.sv
